// File: rtl/core/trilinear_grid_scatter_accumulator_defines.svh
// Assertion macros for the trilinear grid scatter accumulator.
// Used by the top level only; depends on nothing else.
`ifndef TRILINEAR_GRID_SCATTER_ACCUMULATOR_DEFINES_SVH
`define TRILINEAR_GRID_SCATTER_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGSA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgsa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TGSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgsa assertion failed");

`endif

// File: rtl/core/tgsa_pkg.sv
// Shared types and codes for the trilinear grid scatter accumulator.
// Used by the controller, the datapath and the top level.
`default_nettype none

package tgsa_pkg;

  // Operation codes.
  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_DEPOSITED = 2'd0;
  localparam logic [1:0] STAT_ZERO      = 2'd1;
  localparam logic [1:0] STAT_SLOT_BAD  = 2'd2;
  localparam logic [1:0] STAT_READ_DONE = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z  = 3'd6;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         energy_slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] amount;
    logic [3:0]         cell_i;
    logic [3:0]         cell_j;
    logic [3:0]         cell_k;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [47:0] cell_value;
    logic [3:0]         corners_written;
    logic               saturated;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_AXIS,
    S_CORNER,
    S_WZ,
    S_AMT,
    S_ACC,
    S_READ,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic clr_step;
    logic axis_step;
    logic corner_eval;
    logic wz_step;
    logic amt_step;
    logic acc_step;
    logic corner_next;
    logic rd_issue;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_bad;
    logic is_read;
    logic amt_zero;
    logic axis_last;
    logic corner_in;
    logic corner_last;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/tgsa_ctrl.sv
// Controller state machine for the trilinear grid scatter accumulator.
// Depends on tgsa_pkg; drives the datapath through cmd_t and reads stat_t.
`default_nettype none

module tgsa_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  input  tgsa_pkg::stat_t stat,
  output tgsa_pkg::cmd_t  cmd
);

  tgsa_pkg::state_t state_r, state_nxt;

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tgsa_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      tgsa_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = tgsa_pkg::S_IDLE;
      end
      tgsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = tgsa_pkg::S_DECODE;
        end
      end
      tgsa_pkg::S_DECODE: begin
        if (stat.slot_bad) begin
          state_nxt = tgsa_pkg::S_FINISH;
        end else if (stat.is_read) begin
          state_nxt = tgsa_pkg::S_READ;
        end else if (stat.amt_zero) begin
          state_nxt = tgsa_pkg::S_FINISH;
        end else begin
          state_nxt = tgsa_pkg::S_AXIS;
        end
      end
      tgsa_pkg::S_AXIS: begin
        cmd.axis_step = 1'b1;
        if (stat.axis_last) state_nxt = tgsa_pkg::S_CORNER;
      end
      tgsa_pkg::S_CORNER: begin
        cmd.corner_eval = 1'b1;
        if (stat.corner_in) begin
          state_nxt = tgsa_pkg::S_WZ;
        end else if (stat.corner_last) begin
          state_nxt = tgsa_pkg::S_FINISH;
        end else begin
          cmd.corner_next = 1'b1;
        end
      end
      tgsa_pkg::S_WZ: begin
        cmd.wz_step = 1'b1;
        state_nxt   = tgsa_pkg::S_AMT;
      end
      tgsa_pkg::S_AMT: begin
        cmd.amt_step = 1'b1;
        state_nxt    = tgsa_pkg::S_ACC;
      end
      tgsa_pkg::S_ACC: begin
        cmd.acc_step = 1'b1;
        if (stat.corner_last) begin
          state_nxt = tgsa_pkg::S_FINISH;
        end else begin
          cmd.corner_next = 1'b1;
          state_nxt       = tgsa_pkg::S_CORNER;
        end
      end
      tgsa_pkg::S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = tgsa_pkg::S_FINISH;
      end
      tgsa_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = tgsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tgsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/tgsa_datapath.sv
// Datapath of the trilinear grid scatter accumulator: configuration registers,
// axis and weight arithmetic, the accumulator memory and the output register.
// Depends on tgsa_pkg; steered by tgsa_ctrl through cmd_t.
`default_nettype none

module tgsa_datapath #(
  parameter int ENERGY_SLOTS = 8,
  parameter int GRID_X       = 16,
  parameter int GRID_Y       = 16,
  parameter int GRID_Z       = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  tgsa_pkg::in_t                      in_data,
  input  wire                                cfg_valid,
  input  wire  [tgsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [31:0]                        cfg_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output tgsa_pkg::out_t                     out_data,
  input  tgsa_pkg::cmd_t                     cmd,
  output tgsa_pkg::stat_t                    stat
);

  localparam int DEPTH = ENERGY_SLOTS * GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [8:0] GXN = 9'(GRID_X);
  localparam logic [8:0] GYN = 9'(GRID_Y);
  localparam logic [8:0] GZN = 9'(GRID_Z);
  localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

  // Configuration registers.
  logic signed [31:0] origin_x_r, origin_y_r, origin_z_r;
  logic [31:0]        inv_cell_r;
  logic [4:0]         cells_x_r, cells_y_r, cells_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      inv_cell_r <= 32'd65536;
      cells_x_r  <= 5'd16;
      cells_y_r  <= 5'd16;
      cells_z_r  <= 5'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        tgsa_pkg::REG_ORIGIN_X: origin_x_r <= cfg_data;
        tgsa_pkg::REG_ORIGIN_Y: origin_y_r <= cfg_data;
        tgsa_pkg::REG_ORIGIN_Z: origin_z_r <= cfg_data;
        tgsa_pkg::REG_INV_CELL: inv_cell_r <= cfg_data;
        tgsa_pkg::REG_CELLS_X:  cells_x_r  <= cfg_data[4:0];
        tgsa_pkg::REG_CELLS_Y:  cells_y_r  <= cfg_data[4:0];
        tgsa_pkg::REG_CELLS_Z:  cells_z_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Latched item and its decode.
  tgsa_pkg::in_t item_r;
  logic          slot_bad, rd_ok;

  always_ff @(posedge clk) begin
    if (cmd.load_in) item_r <= in_data;
  end

  assign slot_bad = 32'(item_r.energy_slot) >= 32'(ENERGY_SLOTS);
  assign rd_ok    = (32'(item_r.cell_i) < 32'(GRID_X)) &&
                    (32'(item_r.cell_j) < 32'(GRID_Y)) &&
                    (32'(item_r.cell_k) < 32'(GRID_Z));

  // Axis step: one shared multiplier forms (pos - origin) * inv_cell_size per axis.
  logic [1:0]          axis_cnt_r;
  logic signed [33:0]  idx_r  [3];
  logic [15:0]         frac_r [3];
  logic signed [31:0]  ax_pos, ax_org;
  logic signed [32:0]  ax_d;
  logic signed [65:0]  ax_prod;

  always_comb begin
    case (axis_cnt_r)
      2'd0:    begin ax_pos = item_r.pos_x; ax_org = origin_x_r; end
      2'd1:    begin ax_pos = item_r.pos_y; ax_org = origin_y_r; end
      default: begin ax_pos = item_r.pos_z; ax_org = origin_z_r; end
    endcase
    ax_d    = 33'(ax_pos) - 33'(ax_org);
    ax_prod = 66'(ax_d) * 66'($signed({1'b0, inv_cell_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_in) begin
      axis_cnt_r <= '0;
    end else if (cmd.axis_step) begin
      axis_cnt_r <= axis_cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.axis_step) begin
      idx_r[axis_cnt_r]  <= ax_prod[65:32];
      frac_r[axis_cnt_r] <= ax_prod[31:16];
    end
  end

  // Corner evaluation: grid point, bounds check and the first weight product.
  logic [2:0]         corner_r;
  logic [8:0]         n_lim [3];
  logic signed [34:0] pt    [3];
  logic [16:0]        wgt   [3];
  logic [2:0]         ax_in;
  logic               corner_in;
  logic [33:0]        wxy_full;
  logic [16:0]        wxy_r;
  logic [AW-1:0]      addr_r, corner_addr, rd_addr;

  always_comb begin
    n_lim[0] = ({4'b0, cells_x_r} > GXN) ? GXN : {4'b0, cells_x_r};
    n_lim[1] = ({4'b0, cells_y_r} > GYN) ? GYN : {4'b0, cells_y_r};
    n_lim[2] = ({4'b0, cells_z_r} > GZN) ? GZN : {4'b0, cells_z_r};
    for (int a = 0; a < 3; a++) begin
      pt[a]    = 35'(idx_r[a]) + 35'(corner_r[a]);
      ax_in[a] = !pt[a][34] && (pt[a][33:0] < 34'(n_lim[a]));
      wgt[a]   = corner_r[a] ? {1'b0, frac_r[a]} : 17'd65536 - {1'b0, frac_r[a]};
    end
    corner_in   = &ax_in;
    wxy_full    = 34'(wgt[0] * wgt[1]) + 34'd32768;
    corner_addr = ((AW'(item_r.energy_slot) * AW'(GRID_X) + AW'(pt[0])) * AW'(GRID_Y)
                   + AW'(pt[1])) * AW'(GRID_Z) + AW'(pt[2]);
    rd_addr     = ((AW'(item_r.energy_slot) * AW'(GRID_X) + AW'(item_r.cell_i))
                   * AW'(GRID_Y) + AW'(item_r.cell_j)) * AW'(GRID_Z) + AW'(item_r.cell_k);
  end

  always_ff @(posedge clk) begin
    if (cmd.corner_eval) begin
      wxy_r  <= wxy_full[32:16];
      addr_r <= corner_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_in) begin
      corner_r <= '0;
    end else if (cmd.corner_next) begin
      corner_r <= corner_r + 3'd1;
    end
  end

  // Second weight product, then the amount times the weight, each registered.
  logic [33:0]        w_full;
  logic [16:0]        w_r;
  logic signed [49:0] amt_full;
  logic signed [33:0] contrib_r;

  assign w_full   = 34'(wxy_r * wgt[2]) + 34'd32768;
  assign amt_full = 50'(item_r.amount) * 50'($signed({1'b0, w_r})) + 50'sd32768;

  always_ff @(posedge clk) begin
    if (cmd.wz_step)  w_r       <= w_full[32:16];
    if (cmd.amt_step) contrib_r <= amt_full[49:16];
  end

  // Accumulator memory with a clearing sweep after reset.
  logic [47:0]   mem [DEPTH];
  logic [47:0]   rdata_r;
  logic [AW-1:0] clr_cnt_r, mem_raddr, mem_waddr;
  logic [47:0]   mem_wdata;
  logic          mem_we, mem_re;
  logic signed [49:0] sum;
  logic signed [47:0] sum_sat;
  logic          sum_hi, sum_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_comb begin
    sum     = 50'($signed(rdata_r)) + 50'(contrib_r);
    sum_hi  = sum > 50'(ACC_MAX);
    sum_lo  = sum < 50'(ACC_MIN);
    sum_sat = sum_hi ? ACC_MAX : (sum_lo ? ACC_MIN : sum[47:0]);
    mem_we    = cmd.clr_step || cmd.acc_step;
    mem_waddr = cmd.clr_step ? clr_cnt_r : addr_r;
    mem_wdata = cmd.clr_step ? 48'd0 : sum_sat;
    mem_re    = cmd.wz_step || cmd.rd_issue;
    mem_raddr = cmd.rd_issue ? rd_addr : addr_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  // Deposit bookkeeping.
  logic [3:0] written_r;
  logic       sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_in) begin
      written_r <= '0;
      sat_r     <= 1'b0;
    end else if (cmd.acc_step) begin
      written_r <= written_r + 4'd1;
      sat_r     <= sat_r | sum_hi | sum_lo;
    end
  end

  // Output register; holds the result until the transfer completes.
  logic           out_valid_r;
  tgsa_pkg::out_t out_r, out_nxt;

  always_comb begin
    out_nxt = '0;
    if (slot_bad) begin
      out_nxt.status = tgsa_pkg::STAT_SLOT_BAD;
    end else if (item_r.opcode == tgsa_pkg::OP_READ) begin
      out_nxt.status     = tgsa_pkg::STAT_READ_DONE;
      out_nxt.cell_value = rd_ok ? rdata_r : 48'd0;
    end else if (item_r.amount == 32'sd0) begin
      out_nxt.status = tgsa_pkg::STAT_ZERO;
    end else begin
      out_nxt.status          = tgsa_pkg::STAT_DEPOSITED;
      out_nxt.corners_written = written_r;
      out_nxt.saturated       = sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status toward the controller.
  always_comb begin
    stat.slot_bad    = slot_bad;
    stat.is_read     = item_r.opcode == tgsa_pkg::OP_READ;
    stat.amt_zero    = item_r.amount == 32'sd0;
    stat.axis_last   = axis_cnt_r == 2'd2;
    stat.corner_in   = corner_in;
    stat.corner_last = corner_r == 3'd7;
    stat.clr_last    = clr_cnt_r == AW'(DEPTH - 1);
    stat.out_free    = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

// File: rtl/core/trilinear_grid_scatter_accumulator.sv
// Trilinear grid scatter accumulator. After reset the block sweeps the
// accumulator memory to zero, one entry per cycle, over all
// ENERGY_SLOTS*GRID_X*GRID_Y*GRID_Z entries (32768 with the defaults); no item
// is taken during the sweep, configuration writes are. Items are handled one
// at a time. A deposit is decoded and given its three axis products; then
// each grid point inside the grid takes two weight products, the amount
// product and a read-modify-write on the accumulator memory (one read port,
// one write port), each point outside it is only checked, and the result is
// posted. A read is decoded, reads its cell and posts; a bad slot or a zero
// amount is decoded and posted. A finished result sits in an output register, so the next
// item is accepted while it waits to be taken.
// Depends on tgsa_pkg, tgsa_ctrl and tgsa_datapath.
`default_nettype none
`include "trilinear_grid_scatter_accumulator_defines.svh"

module trilinear_grid_scatter_accumulator #(
  parameter int ENERGY_SLOTS = 8,
  parameter int GRID_X       = 16,
  parameter int GRID_Y       = 16,
  parameter int GRID_Z       = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  tgsa_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output tgsa_pkg::out_t                 out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [tgsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [31:0]                    cfg_data
);

  tgsa_pkg::cmd_t  cmd;
  tgsa_pkg::stat_t stat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  tgsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tgsa_datapath #(
    .ENERGY_SLOTS (ENERGY_SLOTS),
    .GRID_X       (GRID_X),
    .GRID_Y       (GRID_Y),
    .GRID_Z       (GRID_Z)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  // One item in flight: after a transfer in, no second item is taken next cycle.
  `TGSA_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
  // A deposit never reports more than eight grid points.
  `TGSA_ASSERT_SAME(a_corner_max, clk, rst_n, out_valid, out_data.corners_written <= 4'd8)
  // Only deposits report written points or saturation.
  `TGSA_ASSERT_SAME(a_dep_only, clk, rst_n,
    out_valid && (out_data.status != tgsa_pkg::STAT_DEPOSITED),
    (out_data.corners_written == 4'd0) && !out_data.saturated)
  // Only reads return a value.
  `TGSA_ASSERT_SAME(a_read_only, clk, rst_n,
    out_valid && (out_data.status != tgsa_pkg::STAT_READ_DONE),
    out_data.cell_value == 48'sd0)

endmodule

`default_nettype wire

// File: dv/tb_trilinear_grid_scatter_accumulator.sv
// Self-checking testbench for the trilinear grid scatter accumulator.
// Depends on tgsa_pkg and on the top level trilinear_grid_scatter_accumulator.
`timescale 1ns / 1ps

module tb_trilinear_grid_scatter_accumulator;

  localparam int SLOTS = 8;
  localparam int GX = 16;
  localparam int GY = 16;
  localparam int GZ = 16;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  tgsa_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  tgsa_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [tgsa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  trilinear_grid_scatter_accumulator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the grid and of the registers.
  logic signed [47:0] grid_acc [0:SLOTS*GX*GY*GZ-1];
  logic signed [31:0] org_x, org_y, org_z;
  logic [31:0] inv_cell;
  logic [4:0] pts_x, pts_y, pts_z;

  tgsa_pkg::in_t pending_items[$];
  tgsa_pkg::out_t expected_results[$];
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  bit in_fire;
  bit failed;

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Split one axis into a base index and a Q0.16 fraction.
  function automatic void split_axis(input logic signed [31:0] p, input logic signed [31:0] o,
                                     output longint idx, output longint frac);
    longint d;
    longint u;
    d = longint'(p) - longint'(o);
    u = d * longint'(inv_cell[31:16]) + ((d * longint'(inv_cell[15:0])) >>> 16);
    idx = u >>> 16;
    frac = u & 64'hFFFF;
  endfunction

  function automatic longint clamp_pts(input logic [4:0] c, input int g);
    return (c > g) ? g : c;
  endfunction

  // Apply one item to the shadow grid and return the result it must give.
  function automatic tgsa_pkg::out_t deposit_or_read(input tgsa_pkg::in_t it);
    tgsa_pkg::out_t r;
    longint ix, iy, iz, fx, fy, fz, nx, ny, nz;
    longint px, py, pz, wx, wy, wz, wxy, w, contrib, sum;
    int a;
    r = '0;
    if (it.energy_slot >= SLOTS) begin
      r.status = tgsa_pkg::STAT_SLOT_BAD;
    end else if (it.opcode == tgsa_pkg::OP_READ) begin
      r.status = tgsa_pkg::STAT_READ_DONE;
      r.cell_value = grid_acc[((it.energy_slot * GX + it.cell_i) * GY + it.cell_j) * GZ
                              + it.cell_k];
    end else if (it.amount == 0) begin
      r.status = tgsa_pkg::STAT_ZERO;
    end else begin
      r.status = tgsa_pkg::STAT_DEPOSITED;
      nx = clamp_pts(pts_x, GX);
      ny = clamp_pts(pts_y, GY);
      nz = clamp_pts(pts_z, GZ);
      split_axis(it.pos_x, org_x, ix, fx);
      split_axis(it.pos_y, org_y, iy, fy);
      split_axis(it.pos_z, org_z, iz, fz);
      for (int c = 0; c < 8; c++) begin
        px = ix + (c & 1);
        py = iy + ((c >> 1) & 1);
        pz = iz + ((c >> 2) & 1);
        if (px < 0 || px >= nx || py < 0 || py >= ny || pz < 0 || pz >= nz) continue;
        wx = (c & 1) ? fx : 65536 - fx;
        wy = ((c >> 1) & 1) ? fy : 65536 - fy;
        wz = ((c >> 2) & 1) ? fz : 65536 - fz;
        wxy = (wx * wy + 32768) >>> 16;
        w = (wxy * wz + 32768) >>> 16;
        contrib = (longint'(it.amount) * w + 32768) >>> 16;
        a = ((int'(it.energy_slot) * GX + int'(px)) * GY + int'(py)) * GZ + int'(pz);
        sum = longint'(grid_acc[a]) + contrib;
        if (sum > ACC_HI) begin
          sum = ACC_HI;
          r.saturated = 1'b1;
        end
        if (sum < ACC_LO) begin
          sum = ACC_LO;
          r.saturated = 1'b1;
        end
        grid_acc[a] = sum[47:0];
        r.corners_written = r.corners_written + 4'd1;
      end
    end
    return r;
  endfunction

  // Driver: offers the next pending item, with random gaps.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk) begin
    tgsa_pkg::out_t exp_r;
    in_fire <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) expected_results.push_back(deposit_or_read(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        failed = 1'b1;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.status !== exp_r.status)
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_data.status);
        if (out_data.cell_value !== exp_r.cell_value)
          $display("%0t: cell_value expected %0d actual %0d", $time, exp_r.cell_value,
                   out_data.cell_value);
        if (out_data.corners_written !== exp_r.corners_written)
          $display("%0t: corners_written expected %0d actual %0d", $time,
                   exp_r.corners_written, out_data.corners_written);
        if (out_data.saturated !== exp_r.saturated)
          $display("%0t: saturated expected %0d actual %0d", $time, exp_r.saturated,
                   out_data.saturated);
        if (out_data !== exp_r) failed = 1'b1;
      end
    end
  end

  // One register write over the configuration channel.
  task automatic write_reg(input logic [tgsa_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tgsa_pkg::REG_ORIGIN_X: org_x = val;
      tgsa_pkg::REG_ORIGIN_Y: org_y = val;
      tgsa_pkg::REG_ORIGIN_Z: org_z = val;
      tgsa_pkg::REG_INV_CELL: inv_cell = val;
      tgsa_pkg::REG_CELLS_X:  pts_x = val[4:0];
      tgsa_pkg::REG_CELLS_Y:  pts_y = val[4:0];
      tgsa_pkg::REG_CELLS_Z:  pts_z = val[4:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [31:0] ox, oy, oz, inv,
                              input logic [4:0] cx, cy, cz);
    write_reg(tgsa_pkg::REG_ORIGIN_X, ox);
    write_reg(tgsa_pkg::REG_ORIGIN_Y, oy);
    write_reg(tgsa_pkg::REG_ORIGIN_Z, oz);
    write_reg(tgsa_pkg::REG_INV_CELL, inv);
    write_reg(tgsa_pkg::REG_CELLS_X, {27'd0, cx});
    write_reg(tgsa_pkg::REG_CELLS_Y, {27'd0, cy});
    write_reg(tgsa_pkg::REG_CELLS_Z, {27'd0, cz});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Let the block drain before the next register write.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Position whose grid coordinate along one axis lands near the grid in use.
  function automatic logic [31:0] near_grid(input logic signed [31:0] o, input int span);
    longint u;
    longint p;
    u = longint'($urandom_range(span * 65536 + 131072)) - 131072;
    p = longint'(o) + (u * 65536) / longint'(inv_cell);
    if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
    if (p < -64'sh8000_0000) p = -64'sh8000_0000;
    return p[31:0];
  endfunction

  function automatic tgsa_pkg::in_t make_item(input logic op, input logic [7:0] slot,
                                              input logic [31:0] x, y, z, amt,
                                              input logic [3:0] ci, cj, ck);
    tgsa_pkg::in_t it;
    it.opcode = op;
    it.energy_slot = slot;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.amount = amt;
    it.cell_i = ci;
    it.cell_j = cj;
    it.cell_k = ck;
    return it;
  endfunction

  // Mostly well-formed deposits and reads near the grid, some noise.
  task automatic queue_random(input int n);
    tgsa_pkg::in_t it;
    int pick;
    for (int i = 0; i < n; i++) begin
      it = make_item($urandom_range(99) < 35 ? tgsa_pkg::OP_READ : tgsa_pkg::OP_DEPOSIT,
                     $urandom_range(99) < 8 ? $urandom_range(255) : $urandom_range(SLOTS - 1),
                     near_grid(org_x, 17), near_grid(org_y, 17), near_grid(org_z, 17),
                     $urandom(), $urandom_range(15), $urandom_range(15), $urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 5) it.amount = 0;
      else if (pick < 10) it.amount = 32'h7FFF_FFFF;
      else if (pick < 15) it.amount = 32'h8000_0000;
      else if (pick < 25) begin
        it.pos_x = $urandom();
        it.pos_y = $urandom();
        it.pos_z = $urandom();
      end
      if (it.opcode == tgsa_pkg::OP_READ && $urandom_range(1)) begin
        it.cell_i = $urandom_range(3);
        it.cell_j = $urandom_range(3);
        it.cell_k = $urandom_range(3);
      end
      pending_items.push_back(it);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    in_fire = 1'b0;
    failed = 1'b0;
    foreach (grid_acc[i]) grid_acc[i] = '0;
    org_x = 0;
    org_y = 0;
    org_z = 0;
    inv_cell = 32'd65536;
    pts_x = 5'd16;
    pts_y = 5'd16;
    pts_z = 5'd16;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items under the reset setting.
    pending_items.push_back(make_item(tgsa_pkg::OP_DEPOSIT, 0, 0, 0, 0, 32'h7FFF_FFFF,
                                      0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_DEPOSIT, 0, 0, 0, 0, 32'h8000_0000,
                                      0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_DEPOSIT, 0, 32'h0000_8000, 32'h0001_4000,
                                      32'h0002_C000, 32'h0001_0000, 0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_DEPOSIT, 7, 32'h000F_8000, 32'h000F_8000,
                                      32'h000F_8000, 32'h0003_0000, 0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_DEPOSIT, 1, 32'hFFFF_8000, 32'h0000_4000,
                                      32'h0000_4000, 32'hFFFF_0000, 0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_DEPOSIT, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'h0001_0000, 0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_DEPOSIT, 2, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h0001_0000, 0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_DEPOSIT, 3, 32'h0005_0000, 32'h0005_0000,
                                      32'h0005_0000, 32'h0000_0001, 0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_DEPOSIT, 3, 32'h0005_0000, 0, 0, 0,
                                      0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_DEPOSIT, 8, 0, 0, 0, 32'h0001_0000,
                                      0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_DEPOSIT, 255, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_READ, 255, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_READ, 0, 0, 1, 2, 0, 0, 1, 2));
    pending_items.push_back(make_item(tgsa_pkg::OP_READ, 7, 0, 0, 0, 0, 15, 15, 15));
    pending_items.push_back(make_item(tgsa_pkg::OP_READ, 1, 0, 0, 0, 0, 15, 0, 0));
    pending_items.push_back(make_item(tgsa_pkg::OP_READ, 3, 0, 0, 0, 0, 5, 5, 5));
    drain();

    // Phase 1: grid corner at the extremes, one axis with no points.
    load_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'd65536, 5'd1, 5'd16, 5'd0);
    queue_random(40);
    drain();

    // Phase 2: long receiver hold-off so the block backs up.
    load_setting(32'hFFFE_0000, 32'h0001_0000, 32'h0, 32'd65536, 5'd16, 5'd16, 5'd16);
    hold_req = 1'b1;
    queue_random(100);
    drain();

    // Phase 3: smallest cell scale and oversized point counts, sender idle.
    send_idle_pct = 59;
    load_setting($urandom(), $urandom(), $urandom(), 32'd1, 5'd31, 5'd5, 5'd17);
    queue_random(40);
    drain();

    // Phase 4: largest cell scale, receiver stalling.
    send_idle_pct = 0;
    recv_stall_pct = 59;
    load_setting(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 5'd16, 5'd2, 5'd16);
    queue_random(40);
    drain();

    // Phase 5: half-size cells, both sides idling.
    send_idle_pct = 26;
    recv_stall_pct = 26;
    load_setting(32'h0003_8000, 32'hFFFF_C000, 32'h0000_0001, 32'd131072,
                 $urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16));
    queue_random(130);
    drain();

    // Phase 6: unit cells again with no idling.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_setting(32'h0, 32'h0, 32'h0, 32'd65536, 5'd16, 5'd16, 5'd16);
    queue_random(130);
    drain();

    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
